// ----- rtl/grt_pkg.sv -----
// ----------------------------------------------------------------------------
// grt_pkg
// Shared types, constants and arithmetic helpers for the grid ray traversal.
// ----------------------------------------------------------------------------
package grt_pkg;

  // width of a signed tile index, covers -1 up to the largest map plus one
  localparam int CELL_W    = 12;
  // width of a boundary distance, wide enough to hold the saturated value
  localparam int DIST_W    = 40;
  localparam logic [DIST_W-1:0] T_SAT = 40'hFF_FFFF_FFFF;

  // shared divider
  localparam int DIV_W     = 32;
  localparam int DIVS_W    = 16;
  localparam int DIV_STEPS = 32;
  localparam int DIV_LAT   = DIV_STEPS + 1;

  // end point saturation bounds
  localparam logic signed [23:0] HIT_MIN = -24'sd524288;
  localparam logic signed [23:0] HIT_MAX = 24'sd1048575;

  typedef enum logic [2:0] {
    DSEL_TX,
    DSEL_TY,
    DSEL_DX,
    DSEL_DY
  } div_sel_t;

  // controller to datapath
  typedef struct packed {
    logic     clr_en;
    logic     tile_wr;
    logic     cap;
    logic     div_start;
    div_sel_t div_sel;
    logic     step;
    logic     set_org;
    logic     fin_ray;
    logic     fin_stop;
    logic     mul;
    logic     load_out;
  } grt_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic div_done;
    logic org_out;
    logic blk;
    logic oob;
    logic t_le_max;
  } grt_sts_t;

  // saturating add of two boundary distances
  function automatic logic [DIST_W-1:0] sat_add(input logic [DIST_W-1:0] a,
                                                input logic [DIST_W-1:0] b);
    logic [DIST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (a >= T_SAT || b >= T_SAT || s > {1'b0, T_SAT}) begin
      return T_SAT;
    end
    return s[DIST_W-1:0];
  endfunction

  // magnitude of a Q2.14 direction
  function automatic logic [15:0] abs16(input logic signed [15:0] d);
    return d[15] ? (~d + 16'd1) : d;
  endfunction

  // origin plus the signed product, rounded toward minus infinity and clamped to the result range
  function automatic logic [20:0] end_point(input logic [18:0] p0,
                                            input logic        neg,
                                            input logic [34:0] mag);
    logic [21:0]        q;
    logic signed [23:0] v;
    q = {1'b0, mag[34:14]} + {21'd0, (neg && (|mag[13:0]))};
    if (neg) begin
      v = $signed({5'd0, p0}) - $signed({2'd0, q});
    end else begin
      v = $signed({5'd0, p0}) + $signed({2'd0, q});
    end
    if (v < HIT_MIN) begin
      return 21'h18_0000;
    end
    if (v > HIT_MAX) begin
      return 21'h0F_FFFF;
    end
    return v[20:0];
  endfunction

endpackage

// ----- rtl/grt_div.sv -----
// ----------------------------------------------------------------------------
// grt_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module grt_div
  import grt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIV_W-1:0]  dividend,
  input  logic [DIVS_W-1:0] divisor,
  output logic              done,
  output logic [DIV_W-1:0]  quotient
);

  logic [5:0]        cnt_r;
  logic              done_r;
  logic [DIV_W-1:0]  dvd_r;
  logic [DIVS_W-1:0] dvs_r;
  logic [DIVS_W-1:0] rem_r;
  logic [DIVS_W:0]   rem_sh;
  logic              q_bit;

  // one restoring step
  always_comb begin
    rem_sh = {rem_r, dvd_r[DIV_W-1]};
    q_bit  = (rem_sh >= {1'b0, dvs_r});
  end

  // step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= 6'(DIV_STEPS);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  // operand and remainder registers
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (cnt_r != '0) begin
      dvd_r <= {dvd_r[DIV_W-2:0], q_bit};
      rem_r <= q_bit ? DIVS_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[DIVS_W-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = dvd_r;

endmodule

// ----- rtl/grt_datapath.sv -----
// ----------------------------------------------------------------------------
// grt_datapath
// Tile map memory, ray registers, step logic, end point products and
// result registers.
// ----------------------------------------------------------------------------
module grt_datapath
  import grt_pkg::*;
#(
  parameter int MAP_COLS    = 32,
  parameter int MAP_ROWS    = 32,
  parameter int TILE_PIXELS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  grt_cmd_t          cmd,
  output grt_sts_t          sts,
  input  logic [4:0]        in_tile_col,
  input  logic [4:0]        in_tile_row,
  input  logic              in_tile_blocks,
  input  logic [18:0]       in_origin_x,
  input  logic [18:0]       in_origin_y,
  input  logic signed [15:0] in_dir_x,
  input  logic signed [15:0] in_dir_y,
  input  logic [18:0]       in_max_distance,
  output logic signed [20:0] out_hit_x,
  output logic signed [20:0] out_hit_y,
  output logic [18:0]       out_travel,
  output logic              out_blocked
);

  localparam int CW    = (MAP_COLS > 1) ? $clog2(MAP_COLS) : 1;
  localparam int RW    = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1;
  localparam int AW    = CW + RW;
  localparam int DEPTH = 1 << AW;
  localparam logic signed [CELL_W-1:0] COLS_S = CELL_W'(MAP_COLS);
  localparam logic signed [CELL_W-1:0] ROWS_S = CELL_W'(MAP_ROWS);
  localparam logic [DIV_W-1:0] STEP_NUM = DIV_W'(TILE_PIXELS) << 22;
  // reciprocal of the tile size, exact for any 11-bit pixel index
  localparam int RECIP_SH = 24;
  localparam logic [23:0] RECIP_M =
    24'(((1 << RECIP_SH) + TILE_PIXELS - 1) / TILE_PIXELS);

  // tile map
  logic           map_mem [DEPTH];
  logic           rd_data_r;
  logic [AW-1:0]  clr_cnt_r;
  logic [AW-1:0]  wr_addr;
  logic [AW-1:0]  rd_addr;
  logic           wr_en;
  logic           wr_data;
  logic           tile_in_map;
  logic [8:0]     col9;
  logic [8:0]     row9;

  // ray registers
  logic [18:0]              ox_r, oy_r, maxd_r;
  logic signed [15:0]       dx_r, dy_r;
  logic signed [CELL_W-1:0] cx_r, cy_r;
  logic [DIST_W-1:0]        tx_r, ty_r, ddx_r, ddy_r, t_r;
  logic                     oob_r;
  logic                     stop_r;
  logic [18:0]              tf_r;
  logic [34:0]              mag_x_r, mag_y_r;
  logic [20:0]              hit_x_r, hit_y_r;
  logic [18:0]              dist_r;
  logic                     blocked_r;

  // origin tile
  logic [34:0]       cx_prod, cy_prod;

  // divider
  logic [DIV_W-1:0]  div_dvd;
  logic [DIVS_W-1:0] div_dvs;
  logic              div_done;
  logic [DIV_W-1:0]  div_quo;
  logic [25:0]       bhx, blx, bhy, bly, num_x, num_y;
  logic [DIST_W-1:0] q_store;
  logic              dir_zero;

  // step
  logic                     tx_lt;
  logic signed [CELL_W-1:0] sx, sy, cx_n, cy_n, rd_cx, rd_cy;
  logic [DIST_W-1:0]        t_n;
  logic                     oob_n;

  // tile write decode, clear sweep and map read address
  always_comb begin
    col9        = {4'd0, in_tile_col};
    row9        = {4'd0, in_tile_row};
    tile_in_map = (col9 < 9'(MAP_COLS)) && (row9 < 9'(MAP_ROWS));
    wr_en       = cmd.clr_en || (cmd.tile_wr && tile_in_map);
    wr_addr     = cmd.clr_en ? clr_cnt_r : {row9[RW-1:0], col9[CW-1:0]};
    wr_data     = cmd.clr_en ? 1'b0 : in_tile_blocks;
    rd_cx       = cmd.step ? cx_n : cx_r;
    rd_cy       = cmd.step ? cy_n : cy_r;
    rd_addr     = {rd_cy[RW-1:0], rd_cx[CW-1:0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_en) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      map_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= map_mem[rd_addr];
  end

  // origin tile from the pixel index by reciprocal multiplication
  always_comb begin
    cx_prod = 35'(in_origin_x[18:8]) * 35'(RECIP_M);
    cy_prod = 35'(in_origin_y[18:8]) * 35'(RECIP_M);
  end

  // divider operand select
  always_comb begin
    bhx   = (26'(cx_r[CELL_W-2:0]) + 26'd1) * 26'(TILE_PIXELS) << 8;
    blx   = 26'(cx_r[CELL_W-2:0]) * 26'(TILE_PIXELS) << 8;
    bhy   = (26'(cy_r[CELL_W-2:0]) + 26'd1) * 26'(TILE_PIXELS) << 8;
    bly   = 26'(cy_r[CELL_W-2:0]) * 26'(TILE_PIXELS) << 8;
    num_x = dx_r[15] ? (26'(ox_r) - blx) : (bhx - 26'(ox_r));
    num_y = dy_r[15] ? (26'(oy_r) - bly) : (bhy - 26'(oy_r));
    unique case (cmd.div_sel)
      DSEL_TX: begin
        div_dvd = {num_x[17:0], 14'd0};
        div_dvs = abs16(dx_r);
      end
      DSEL_TY: begin
        div_dvd = {num_y[17:0], 14'd0};
        div_dvs = abs16(dy_r);
      end
      DSEL_DX: begin
        div_dvd = STEP_NUM;
        div_dvs = abs16(dx_r);
      end
      DSEL_DY: begin
        div_dvd = STEP_NUM;
        div_dvs = abs16(dy_r);
      end
      default: begin
        div_dvd = STEP_NUM;
        div_dvs = DIVS_W'(TILE_PIXELS);
      end
    endcase
    dir_zero = (div_dvs == '0);
    q_store  = dir_zero ? T_SAT : DIST_W'(div_quo);
  end

  grt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_quo)
  );

  // one tile boundary step
  always_comb begin
    tx_lt = (tx_r < ty_r);
    sx    = dx_r[15] ? -CELL_W'(1) : CELL_W'(1);
    sy    = dy_r[15] ? -CELL_W'(1) : CELL_W'(1);
    cx_n  = tx_lt ? cx_r + sx : cx_r;
    cy_n  = tx_lt ? cy_r : cy_r + sy;
    t_n   = tx_lt ? tx_r : ty_r;
    oob_n = (cx_n < 0) || (cx_n >= COLS_S) || (cy_n < 0) || (cy_n >= ROWS_S);
  end

  // ray registers
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      ox_r   <= in_origin_x;
      oy_r   <= in_origin_y;
      dx_r   <= in_dir_x;
      dy_r   <= in_dir_y;
      maxd_r <= in_max_distance;
      cx_r   <= CELL_W'(cx_prod[34:RECIP_SH]);
      cy_r   <= CELL_W'(cy_prod[34:RECIP_SH]);
    end
    if (div_done) begin
      unique case (cmd.div_sel)
        DSEL_TX: tx_r  <= q_store;
        DSEL_TY: ty_r  <= q_store;
        DSEL_DX: ddx_r <= q_store;
        DSEL_DY: ddy_r <= q_store;
        default: ddy_r <= q_store;
      endcase
    end
    if (cmd.step) begin
      cx_r  <= cx_n;
      cy_r  <= cy_n;
      t_r   <= t_n;
      oob_r <= oob_n;
      if (tx_lt) begin
        tx_r <= sat_add(tx_r, ddx_r);
      end else begin
        ty_r <= sat_add(ty_r, ddy_r);
      end
    end
    // final distance
    if (cmd.set_org) begin
      stop_r <= 1'b1;
      tf_r   <= '0;
    end else if (cmd.fin_ray) begin
      stop_r <= cmd.fin_stop;
      tf_r   <= (!cmd.fin_stop || (t_r > DIST_W'(maxd_r))) ? maxd_r : t_r[18:0];
    end
    // end point products
    if (cmd.mul) begin
      mag_x_r <= 35'(abs16(dx_r)) * 35'(tf_r);
      mag_y_r <= 35'(abs16(dy_r)) * 35'(tf_r);
    end
    // result item
    if (cmd.load_out) begin
      hit_x_r   <= end_point(ox_r, dx_r[15], mag_x_r);
      hit_y_r   <= end_point(oy_r, dy_r[15], mag_y_r);
      dist_r    <= tf_r;
      blocked_r <= stop_r;
    end
  end

  // status
  always_comb begin
    sts.clr_last = (clr_cnt_r == AW'(DEPTH - 1));
    sts.div_done = div_done;
    sts.org_out  = (cx_r >= COLS_S) || (cy_r >= ROWS_S);
    sts.blk      = rd_data_r;
    sts.oob      = oob_r;
    sts.t_le_max = (t_r <= DIST_W'(maxd_r));
  end

  assign out_hit_x   = hit_x_r;
  assign out_hit_y   = hit_y_r;
  assign out_travel  = dist_r;
  assign out_blocked = blocked_r;

endmodule

// ----- rtl/grt_ctrl.sv -----
// ----------------------------------------------------------------------------
// grt_ctrl
// Sequencer: map clear, division order, traversal loop and result handoff.
// ----------------------------------------------------------------------------
module grt_ctrl
  import grt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     in_req_type,
  output logic     out_valid,
  input  logic     out_ready,
  output grt_cmd_t cmd,
  input  grt_sts_t sts
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_ORG,
    S_ORGCHK,
    S_STEP,
    S_CHK,
    S_MUL,
    S_OUT
  } state_t;

  state_t   state_r;
  div_sel_t sel_r;
  logic     go_r;
  logic     out_valid_r;
  logic     acc;
  logic     ray_stop;

  assign in_ready = (state_r == S_IDLE);
  assign acc      = in_valid && in_ready;
  assign ray_stop = sts.oob || sts.blk;

  // commands
  always_comb begin
    cmd           = '0;
    cmd.div_sel   = sel_r;
    cmd.div_start = go_r;
    cmd.clr_en    = (state_r == S_CLEAR);
    cmd.tile_wr   = acc && !in_req_type;
    cmd.cap       = acc && in_req_type;
    cmd.step      = (state_r == S_STEP);
    cmd.set_org   = (state_r == S_ORGCHK) && (sts.org_out || sts.blk);
    cmd.fin_ray   = (state_r == S_CHK) && (ray_stop || !sts.t_le_max);
    cmd.fin_stop  = ray_stop;
    cmd.mul       = (state_r == S_MUL);
    cmd.load_out  = (state_r == S_OUT) && (!out_valid_r || out_ready);
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      sel_r       <= DSEL_TX;
      go_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      go_r <= 1'b0;
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          if (sts.clr_last) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (acc && in_req_type) begin
            state_r <= S_ORG;
          end
        end
        S_DIV: begin
          if (sts.div_done) begin
            unique case (sel_r)
              DSEL_TX: begin
                sel_r <= DSEL_TY;
                go_r  <= 1'b1;
              end
              DSEL_TY: begin
                sel_r <= DSEL_DX;
                go_r  <= 1'b1;
              end
              DSEL_DX: begin
                sel_r <= DSEL_DY;
                go_r  <= 1'b1;
              end
              DSEL_DY: state_r <= S_STEP;
              default: state_r <= S_STEP;
            endcase
          end
        end
        S_ORG: state_r <= S_ORGCHK;
        S_ORGCHK: begin
          if (sts.org_out || sts.blk) begin
            state_r <= S_MUL;
          end else begin
            sel_r   <= DSEL_TX;
            go_r    <= 1'b1;
            state_r <= S_DIV;
          end
        end
        S_STEP: state_r <= S_CHK;
        S_CHK: begin
          if (ray_stop || !sts.t_le_max) begin
            state_r <= S_MUL;
          end else begin
            state_r <= S_STEP;
          end
        end
        S_MUL: state_r <= S_OUT;
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;

`ifndef ASSERT_OFF
  // each divider start is answered by a done
  a_div_lat: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> ##DIV_LAT sts.div_done)
    else $error("divider done out of step with start");

  // every step is followed by its map check
  a_step_chk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_STEP) |=> (state_r == S_CHK))
    else $error("step not followed by check");

  // a loaded result is offered on the next cycle
  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid_r)
    else $error("loaded result item not offered");
`endif

endmodule

// ----- rtl/grid_ray_traversal.sv -----
// ----------------------------------------------------------------------------
// grid_ray_traversal
// Tile map with one blocking bit per tile and a grid DDA ray caster.
// ----------------------------------------------------------------------------
// After reset the map is cleared one tile per cycle, all 2^(clog2(MAP_COLS) +
// clog2(MAP_ROWS)) entries (1024 at the defaults), and no item is taken in
// that time. A tile write item is written as it is taken, and the block
// stays ready for the next item. A ray item finds its origin tile by a
// reciprocal multiplication as it is taken; a rejected origin (off the map
// or on a blocking tile) goes straight on to the end point products and the
// result, with no division. Otherwise four divisions on one shared radix-2
// divider give the boundary and step distances, each yielding 32 quotient
// bits between its start and its done, and the walk then does a step and a
// check of the registered map read for each tile crossed. The result sits in
// an output register, and the next item is taken while it waits.
// ----------------------------------------------------------------------------
module grid_ray_traversal
  import grt_pkg::*;
#(
  parameter int MAP_COLS    = 32,
  parameter int MAP_ROWS    = 32,
  parameter int TILE_PIXELS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_req_type,
  input  logic [4:0]         in_tile_col,
  input  logic [4:0]         in_tile_row,
  input  logic               in_tile_blocks,
  input  logic [18:0]        in_origin_x,
  input  logic [18:0]        in_origin_y,
  input  logic signed [15:0] in_dir_x,
  input  logic signed [15:0] in_dir_y,
  input  logic [18:0]        in_max_distance,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [20:0] out_hit_x,
  output logic signed [20:0] out_hit_y,
  output logic [18:0]        out_travel,
  output logic               out_blocked
);

  grt_cmd_t cmd;
  grt_sts_t sts;

  // sequencer
  grt_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_req_type),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .cmd         (cmd),
    .sts         (sts)
  );

  // map, arithmetic and result registers
  grt_datapath #(
    .MAP_COLS    (MAP_COLS),
    .MAP_ROWS    (MAP_ROWS),
    .TILE_PIXELS (TILE_PIXELS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_tile_col      (in_tile_col),
    .in_tile_row      (in_tile_row),
    .in_tile_blocks   (in_tile_blocks),
    .in_origin_x      (in_origin_x),
    .in_origin_y      (in_origin_y),
    .in_dir_x         (in_dir_x),
    .in_dir_y         (in_dir_y),
    .in_max_distance  (in_max_distance),
    .out_hit_x        (out_hit_x),
    .out_hit_y        (out_hit_y),
    .out_travel       (out_travel),
    .out_blocked      (out_blocked)
  );

endmodule
